// File: hdl/thfe_pkg.sv
`timescale 1ns / 1ps
package thfe_pkg;

   localparam int SNI_MAX_DEF = 255;

   localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'h16;
   localparam logic [15:0] GREASE_MASK        = 16'h0f0f;
   localparam logic [15:0] GREASE_PATTERN     = 16'h0a0a;
   localparam logic [15:0] VER_SSL2           = 16'h0200;
   localparam logic [15:0] VER_SSL3           = 16'h0300;
   localparam logic [15:0] VER_TLS10          = 16'h0301;
   localparam logic [15:0] VER_TLS11          = 16'h0302;
   localparam logic [15:0] VER_TLS12          = 16'h0303;
   localparam logic [15:0] RAND_LEN           = 16'd32;
   localparam logic [16:0] MSG_LEN_MAX        = 17'h1ffff;
   localparam logic [15:0] EXT_SNI            = 16'd0;
   localparam logic [15:0] EXT_CURVES         = 16'd10;
   localparam logic [15:0] EXT_POINT_FMT      = 16'd11;
   localparam logic [7:0]  MSG_CLIENT_HELLO   = 8'd1;
   localparam logic [7:0]  MSG_SERVER_HELLO   = 8'd2;

   // inner-list marks kept in the hold byte between extension type and length
   localparam logic [7:0] EXT_MARK_NONE  = 8'd0;
   localparam logic [7:0] EXT_MARK_SNI   = 8'd1;
   localparam logic [7:0] EXT_MARK_CURVE = 8'd2;
   localparam logic [7:0] EXT_MARK_PF    = 8'd3;

   typedef enum logic [4:0] {
      P_RTYPE, P_RVER, P_RLEN, P_MTYPE, P_MLEN, P_HVER, P_RAND, P_SIDLEN,
      P_SID, P_CSLEN, P_CIPHERS, P_CMLEN, P_CM, P_SCIPHER, P_SCOMP, P_EXTLEN,
      P_EXTTYPE, P_EXTLEN2, P_EXTSKIP, P_SNIHDR, P_SNINAME, P_CURVELEN,
      P_CURVES, P_PFLEN, P_PF, P_DONE, P_SINK
   } phase_type;

   typedef enum logic [3:0] {
      K_REC_VER, K_HELLO_KIND, K_HELLO_VER, K_CIPHER, K_EXT_TYPE, K_SNI_BYTE,
      K_CURVE, K_POINT_FMT, K_ACCEPT, K_REJECT
   } kind_type;

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [15:0] field_value;
      logic        packet_done;
   } rsp_word_type;

   function automatic logic is_grease(input logic [15:0] v);
      return ((v & GREASE_MASK) == GREASE_PATTERN) && (v[15:8] == v[7:0]);
   endfunction

   function automatic logic version_ok(input logic [15:0] v);
      return v == VER_SSL2 || v == VER_SSL3 || v == VER_TLS10 ||
             v == VER_TLS11 || v == VER_TLS12;
   endfunction

endpackage

// File: hdl/thfe_req_if.sv
`timescale 1ns / 1ps
interface thfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;
   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// File: hdl/thfe_rsp_if.sv
`timescale 1ns / 1ps
interface thfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_kind;
   logic [15:0] field_value;
   logic        packet_done;
   modport source (output valid, output field_kind, output field_value,
                   output packet_done, input ready);
   modport sink (input valid, input field_kind, input field_value,
                 input packet_done, output ready);
endinterface

// File: hdl/tls_hello_field_extractor.sv
`timescale 1ns / 1ps
// A field word is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one word and the
// receiver takes each word; a byte with a field and the packet status puts two words
// in the 4-entry result queue, which drains one word per cycle while rsp_port.ready is high.
// Reset (synchronous, active high) returns the parser to the record type byte
// and empties the result queue.
module tls_hello_field_extractor #(
   parameter int SNI_MAX = thfe_pkg::SNI_MAX_DEF
) (
   input logic      clock,
   input logic      reset,
   thfe_req_if.sink   req_port,
   thfe_rsp_if.source rsp_port
);
   import thfe_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [15:0]  count_ff, count_in;
   logic [7:0]   hold_ff, hold_in;
   logic [16:0]  rec_ff, rec_in;
   logic [16:0]  ext_ff, ext_in;
   logic [15:0]  body_ff, body_in;
   logic         server_ff, server_in;
   logic         done_ff, done_in;
   logic         err_ff, err_in;
   logic         pkt_ok;

   logic         fld_valid;
   kind_type     fld_kind;
   logic [15:0]  fld_value;

   rsp_word_type q_ff [4];
   logic [1:0]   rd_ff, wr_ff;
   logic [2:0]   cnt_ff;
   logic         accept;
   logic         pop;
   rsp_word_type w0, w1;
   logic         w0_valid, w1_valid;

   logic [7:0]   b;
   logic         eop;
   logic [15:0]  pair;

   assign b    = req_port.data_byte;
   assign eop  = req_port.end_of_packet;
   assign pair = {hold_ff, b};

   assign req_port.ready = (cnt_ff <= 3'd2);
   assign accept         = req_port.valid && req_port.ready;

   // field emission
   always_comb begin
      fld_valid = 1'b0;
      fld_kind  = K_REC_VER;
      fld_value = pair;
      unique case (phase_ff)
         P_RVER: begin
            fld_valid = (count_ff != 16'd0);
            fld_kind  = K_REC_VER;
         end
         P_HVER: begin
            fld_valid = (count_ff != 16'd0);
            fld_kind  = K_HELLO_VER;
         end
         P_MTYPE: begin
            fld_valid = (b == MSG_CLIENT_HELLO) || (b == MSG_SERVER_HELLO);
            fld_kind  = K_HELLO_KIND;
            fld_value = {8'd0, b};
         end
         P_CIPHERS: begin
            fld_valid = (count_ff != 16'd0) && !is_grease(pair);
            fld_kind  = K_CIPHER;
         end
         P_SCIPHER: begin
            fld_valid = (count_ff != 16'd0);
            fld_kind  = K_CIPHER;
         end
         P_EXTTYPE: begin
            fld_valid = (count_ff != 16'd0) && !is_grease(pair);
            fld_kind  = K_EXT_TYPE;
         end
         P_SNINAME: begin
            fld_valid = 1'b1;
            fld_kind  = K_SNI_BYTE;
            fld_value = {8'd0, b};
         end
         P_CURVES: begin
            fld_valid = count_ff[0];
            fld_kind  = K_CURVE;
         end
         P_PF: begin
            fld_valid = 1'b1;
            fld_kind  = K_POINT_FMT;
            fld_value = {8'd0, b};
         end
         default: begin
            fld_valid = 1'b0;
         end
      endcase
   end

   // parser next state
   always_comb begin
      logic [23:0] mlen;
      logic [16:0] mlen_c;
      logic [15:0] v;
      phase_in  = phase_ff;
      count_in  = count_ff;
      hold_in   = hold_ff;
      rec_in    = rec_ff;
      ext_in    = ext_ff;
      body_in   = body_ff;
      server_in = server_ff;
      done_in   = done_ff;
      err_in    = err_ff;
      mlen      = {hold_ff, body_ff[7:0], b};
      mlen_c    = (mlen > {7'd0, MSG_LEN_MAX}) ? MSG_LEN_MAX : mlen[16:0];
      v         = pair;

      if (phase_ff >= P_MTYPE && rec_ff != 17'd0) rec_in = rec_ff - 17'd1;
      if (phase_ff >= P_EXTTYPE && phase_ff <= P_PF && ext_ff != 17'd0)
         ext_in = ext_ff - 17'd1;

      unique case (phase_ff)
         P_RTYPE: begin
            if (b != REC_TYPE_HANDSHAKE) begin
               err_in = 1'b1; phase_in = P_SINK;
            end else begin
               phase_in = P_RVER; count_in = 16'd0;
            end
         end
         P_RVER, P_HVER: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else if (!version_ok(pair)) begin
               err_in = 1'b1; phase_in = P_SINK;
            end else begin
               phase_in = (phase_ff == P_RVER) ? P_RLEN : P_RAND;
               count_in = 16'd0;
            end
         end
         P_RLEN: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else begin
               rec_in = {1'b0, pair}; phase_in = P_MTYPE; count_in = 16'd0;
            end
         end
         P_MTYPE: begin
            if (b == MSG_CLIENT_HELLO) begin
               phase_in = P_MLEN; count_in = 16'd0;
            end else if (b == MSG_SERVER_HELLO) begin
               server_in = 1'b1; phase_in = P_MLEN; count_in = 16'd0;
            end else begin
               err_in = 1'b1; phase_in = P_SINK;
            end
         end
         P_MLEN: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else if (count_ff == 16'd1) begin
               body_in = {8'd0, b}; count_in = 16'd2;
            end else begin
               if (mlen_c > rec_in) rec_in = mlen_c;
               body_in = 16'd0; phase_in = P_HVER; count_in = 16'd0;
            end
         end
         P_RAND: begin
            count_in = count_ff + 16'd1;
            if (count_in >= RAND_LEN) begin
               phase_in = P_SIDLEN; count_in = 16'd0;
            end
         end
         P_SIDLEN, P_SID: begin
            body_in = (phase_ff == P_SIDLEN) ? {8'd0, b} : body_ff - 16'd1;
            if (body_in == 16'd0) begin
               phase_in = server_ff ? P_SCIPHER : P_CSLEN; count_in = 16'd0;
            end else begin
               phase_in = P_SID;
            end
         end
         P_CSLEN: begin
            if (count_ff == 16'd0) begin
               body_in = {8'd0, b}; count_in = 16'd1;
            end else begin
               body_in = {body_ff[7:0], b};
               if (body_in[15:1] == 15'd0) begin
                  err_in = 1'b1; phase_in = P_SINK;
               end else begin
                  phase_in = P_CIPHERS; count_in = 16'd0;
               end
            end
         end
         P_CIPHERS: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else begin
               count_in = 16'd0;
            end
            body_in = body_ff - 16'd1;
            if (body_in == 16'd0) begin
               phase_in = P_CMLEN; count_in = 16'd0;
            end
         end
         P_CMLEN, P_CM: begin
            body_in = (phase_ff == P_CMLEN) ? {8'd0, b} : body_ff - 16'd1;
            if (body_in == 16'd0) begin
               phase_in = P_EXTLEN; count_in = 16'd0;
            end else begin
               phase_in = P_CM;
            end
         end
         P_SCIPHER: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else begin
               phase_in = P_SCOMP; count_in = 16'd0;
            end
         end
         P_SCOMP: begin
            phase_in = P_EXTLEN; count_in = 16'd0;
         end
         P_EXTLEN: begin
            if (count_ff == 16'd0) begin
               ext_in = {9'd0, b}; count_in = 16'd1;
            end else begin
               ext_in = {1'b0, ext_ff[7:0], b};
               if (ext_in == 17'd0 && !server_ff) begin
                  err_in = 1'b1; phase_in = P_SINK;
               end else if (ext_in >= 17'd4) begin
                  phase_in = P_EXTTYPE; count_in = 16'd0;
               end else begin
                  done_in = 1'b1; phase_in = P_DONE; count_in = 16'd0;
               end
            end
         end
         P_EXTTYPE: begin
            if (count_ff == 16'd0) begin
               hold_in = b; count_in = 16'd1;
            end else begin
               hold_in = EXT_MARK_NONE;
               if (!server_ff) begin
                  if (v == EXT_SNI) hold_in = EXT_MARK_SNI;
                  else if (v == EXT_CURVES) hold_in = EXT_MARK_CURVE;
                  else if (v == EXT_POINT_FMT) hold_in = EXT_MARK_PF;
               end
               body_in = 16'd0; phase_in = P_EXTLEN2; count_in = 16'd0;
            end
         end
         P_EXTLEN2: begin
            body_in = {body_ff[7:0], b};
            if (count_ff == 16'd0) begin
               count_in = 16'd1;
            end else begin
               count_in = 16'd0;
               if (body_in == 16'd0) begin
                  if (ext_in >= 17'd4) begin
                     phase_in = P_EXTTYPE;
                  end else begin
                     done_in = 1'b1; phase_in = P_DONE;
                  end
               end else if (hold_ff == EXT_MARK_SNI) phase_in = P_SNIHDR;
               else if (hold_ff == EXT_MARK_CURVE) phase_in = P_CURVELEN;
               else if (hold_ff == EXT_MARK_PF) phase_in = P_PFLEN;
               else phase_in = P_EXTSKIP;
            end
         end
         P_EXTSKIP, P_SNIHDR, P_SNINAME, P_CURVELEN, P_CURVES, P_PFLEN, P_PF: begin
            // inner list byte
            unique case (phase_ff)
               P_SNIHDR: begin
                  if (count_ff == 16'd3) begin
                     hold_in = b; count_in = count_ff + 16'd1;
                  end else if (count_ff == 16'd4) begin
                     if (v > 16'(SNI_MAX)) begin
                        err_in = 1'b1; phase_in = P_SINK;
                     end else if (v == 16'd0) begin
                        phase_in = P_EXTSKIP; count_in = 16'd0;
                     end else begin
                        phase_in = P_SNINAME; count_in = v;
                     end
                  end else begin
                     count_in = count_ff + 16'd1;
                  end
               end
               P_SNINAME, P_PF: begin
                  count_in = count_ff - 16'd1;
                  if (count_in == 16'd0) phase_in = P_EXTSKIP;
               end
               P_CURVELEN: begin
                  if (count_ff == 16'd0) begin
                     hold_in = b; count_in = 16'd1;
                  end else if ({v[15:1], 1'b0} == 16'd0) begin
                     phase_in = P_EXTSKIP; count_in = 16'd0;
                  end else begin
                     phase_in = P_CURVES; count_in = {v[15:1], 1'b0};
                  end
               end
               P_CURVES: begin
                  if (!count_ff[0]) hold_in = b;
                  count_in = count_ff - 16'd1;
                  if (count_in == 16'd0) phase_in = P_EXTSKIP;
               end
               P_PFLEN: begin
                  if (b == 8'd0) begin
                     phase_in = P_EXTSKIP; count_in = 16'd0;
                  end else begin
                     phase_in = P_PF; count_in = {8'd0, b};
                  end
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
            if (phase_in != P_SINK) begin
               body_in = body_ff - 16'd1;
               if (body_in == 16'd0) begin
                  if (phase_in != P_EXTSKIP) begin
                     err_in = 1'b1; phase_in = P_SINK;
                  end else if (ext_in >= 17'd4) begin
                     phase_in = P_EXTTYPE; count_in = 16'd0;
                  end else begin
                     done_in = 1'b1; phase_in = P_DONE; count_in = 16'd0;
                  end
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      pkt_ok = !err_in && done_in && (rec_in == 17'd0);

      if (eop) begin
         phase_in  = P_RTYPE;
         count_in  = 16'd0;
         hold_in   = 8'd0;
         rec_in    = 17'd0;
         ext_in    = 17'd0;
         body_in   = 16'd0;
         server_in = 1'b0;
         done_in   = 1'b0;
         err_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= P_RTYPE;
         count_ff  <= '0;
         hold_ff   <= '0;
         rec_ff    <= '0;
         ext_ff    <= '0;
         body_ff   <= '0;
         server_ff <= 1'b0;
         done_ff   <= 1'b0;
         err_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         hold_ff   <= hold_in;
         rec_ff    <= rec_in;
         ext_ff    <= ext_in;
         body_ff   <= body_in;
         server_ff <= server_in;
         done_ff   <= done_in;
         err_ff    <= err_in;
      end
   end

   // result queue: the field word goes ahead of the status word
   always_comb begin
      rsp_word_type fw, sw;
      fw = '{field_kind: fld_kind, field_value: fld_value, packet_done: 1'b0};
      sw = '{field_kind: (pkt_ok ? K_ACCEPT : K_REJECT), field_value: 16'd0,
             packet_done: 1'b1};
      w0       = fld_valid ? fw : sw;
      w1       = sw;
      w0_valid = accept && (fld_valid || eop);
      w1_valid = accept && fld_valid && eop;
   end

   assign pop = rsp_port.valid && rsp_port.ready;

   always_ff @(posedge clock) begin
      if (w0_valid) q_ff[wr_ff] <= w0;
      if (w1_valid) q_ff[wr_ff + 2'd1] <= w1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + {1'b0, w0_valid} + {1'b0, w1_valid};
         rd_ff  <= rd_ff + {1'b0, pop};
         cnt_ff <= cnt_ff + {2'd0, w0_valid} + {2'd0, w1_valid} - {2'd0, pop};
      end
   end

   assign rsp_port.valid       = (cnt_ff != 3'd0);
   assign rsp_port.field_kind  = q_ff[rd_ff].field_kind;
   assign rsp_port.field_value = q_ff[rd_ff].field_value;
   assign rsp_port.packet_done = q_ff[rd_ff].packet_done;

endmodule

// File: test/thfe_checker.sv
`timescale 1ns / 1ps
module thfe_checker (
   input logic        clock,
   input logic        reset,
   thfe_req_if        req_port,
   thfe_rsp_if        rsp_port,
   output int         fail_count,
   output int         pending_count
);
   import thfe_pkg::*;

   localparam logic [16:0] LEN_CAP = 17'h1ffff;

   phase_type   phase;
   logic [15:0] cnt;
   logic [7:0]  hold;
   logic [16:0] rec_left;
   logic [16:0] ext_left;
   logic [15:0] body_left;
   logic        is_server, hello_done, parse_err;

   rsp_word_type fields_due[$];

   assign pending_count = fields_due.size();

   function automatic logic grease_value(input logic [15:0] v);
      return (v[11:8] == 4'ha) && (v[3:0] == 4'ha) && (v[15:8] == v[7:0]);
   endfunction

   function automatic logic known_version(input logic [15:0] v);
      return v == VER_SSL2 || (v >= VER_SSL3 && v <= VER_TLS12);
   endfunction

   task automatic push_field(input kind_type k, input logic [15:0] v, input logic fin);
      rsp_word_type w;
      w.field_kind  = k;
      w.field_value = v;
      w.packet_done = fin;
      fields_due.push_back(w);
   endtask

   task automatic clear_parser();
      phase = P_RTYPE; cnt = 0; hold = 0; rec_left = 0; ext_left = 0;
      body_left = 0; is_server = 0; hello_done = 0; parse_err = 0;
   endtask

   task automatic abort_parse();
      parse_err = 1;
      phase = P_SINK;
   endtask

   task automatic enter(input phase_type p);
      phase = p;
      cnt = 0;
   endtask

   task automatic next_ext();
      if (ext_left >= 4) enter(P_EXTTYPE);
      else begin
         hello_done = 1;
         enter(P_DONE);
      end
   endtask

   task automatic inner_byte(input logic [7:0] b);
      logic [15:0] v;
      case (phase)
         P_SNIHDR: begin
            if (cnt == 3) begin
               hold = b;
               cnt++;
            end else if (cnt == 4) begin
               v = {hold, b};
               if (v > SNI_MAX_DEF) abort_parse();
               else if (v == 0) enter(P_EXTSKIP);
               else begin
                  phase = P_SNINAME;
                  cnt = v;
               end
            end else cnt++;
         end
         P_SNINAME: begin
            push_field(K_SNI_BYTE, {8'd0, b}, 0);
            cnt--;
            if (cnt == 0) enter(P_EXTSKIP);
         end
         P_CURVELEN: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               v = {hold, b} & 16'hfffe;
               if (v == 0) enter(P_EXTSKIP);
               else begin
                  phase = P_CURVES;
                  cnt = v;
               end
            end
         end
         P_CURVES: begin
            if (!cnt[0]) hold = b;
            else push_field(K_CURVE, {hold, b}, 0);
            cnt--;
            if (cnt == 0) enter(P_EXTSKIP);
         end
         P_PFLEN: begin
            if (b == 0) enter(P_EXTSKIP);
            else begin
               phase = P_PF;
               cnt = {8'd0, b};
            end
         end
         P_PF: begin
            push_field(K_POINT_FMT, {8'd0, b}, 0);
            cnt--;
            if (cnt == 0) enter(P_EXTSKIP);
         end
         default: ;
      endcase
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eop);
      logic [15:0] v;
      logic [16:0] mlen;
      if (phase >= P_MTYPE && rec_left > 0) rec_left--;
      if (phase >= P_EXTTYPE && phase <= P_PF && ext_left > 0) ext_left--;
      case (phase)
         P_RTYPE: if (b != REC_TYPE_HANDSHAKE) abort_parse(); else enter(P_RVER);
         P_RVER, P_HVER: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               v = {hold, b};
               push_field(phase == P_RVER ? K_REC_VER : K_HELLO_VER, v, 0);
               if (!known_version(v)) abort_parse();
               else enter(phase == P_RVER ? P_RLEN : P_RAND);
            end
         end
         P_RLEN: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               rec_left = {1'b0, hold, b};
               enter(P_MTYPE);
            end
         end
         P_MTYPE: begin
            if (b == MSG_CLIENT_HELLO) begin
               push_field(K_HELLO_KIND, 16'd1, 0);
               enter(P_MLEN);
            end else if (b == MSG_SERVER_HELLO) begin
               is_server = 1;
               push_field(K_HELLO_KIND, 16'd2, 0);
               enter(P_MLEN);
            end else abort_parse();
         end
         P_MLEN: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else if (cnt == 1) begin
               body_left = {8'd0, b};
               cnt = 2;
            end else begin
               // saturate 24-bit length to 17 bits
               mlen = (hold > 1) ? LEN_CAP : {hold[0], body_left[7:0], b};
               if (mlen > rec_left) rec_left = mlen;
               body_left = 0;
               enter(P_HVER);
            end
         end
         P_RAND: begin
            cnt++;
            if (cnt >= 32) enter(P_SIDLEN);
         end
         P_SIDLEN, P_SID: begin
            if (phase == P_SIDLEN) body_left = {8'd0, b};
            else body_left--;
            if (body_left == 0) enter(is_server ? P_SCIPHER : P_CSLEN);
            else phase = P_SID;
         end
         P_CSLEN: begin
            if (cnt == 0) begin
               body_left = {8'd0, b};
               cnt = 1;
            end else begin
               body_left = {body_left[7:0], b};
               if (body_left[15:1] == 0) abort_parse(); else enter(P_CIPHERS);
            end
         end
         P_CIPHERS: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               v = {hold, b};
               if (!grease_value(v)) push_field(K_CIPHER, v, 0);
               cnt = 0;
            end
            body_left--;
            if (body_left == 0) enter(P_CMLEN);
         end
         P_CMLEN, P_CM: begin
            if (phase == P_CMLEN) body_left = {8'd0, b};
            else body_left--;
            if (body_left == 0) enter(P_EXTLEN); else phase = P_CM;
         end
         P_SCIPHER: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               push_field(K_CIPHER, {hold, b}, 0);
               enter(P_SCOMP);
            end
         end
         P_SCOMP: enter(P_EXTLEN);
         P_EXTLEN: begin
            if (cnt == 0) begin
               ext_left = {9'd0, b};
               cnt = 1;
            end else begin
               ext_left = {1'b0, ext_left[7:0], b};
               if (ext_left == 0 && !is_server) abort_parse();
               else next_ext();
            end
         end
         P_EXTTYPE: begin
            if (cnt == 0) begin
               hold = b;
               cnt = 1;
            end else begin
               v = {hold, b};
               if (!grease_value(v)) push_field(K_EXT_TYPE, v, 0);
               hold = EXT_MARK_NONE;
               if (!is_server) begin
                  if (v == EXT_SNI) hold = EXT_MARK_SNI;
                  else if (v == EXT_CURVES) hold = EXT_MARK_CURVE;
                  else if (v == EXT_POINT_FMT) hold = EXT_MARK_PF;
               end
               body_left = 0;
               enter(P_EXTLEN2);
            end
         end
         P_EXTLEN2: begin
            body_left = {body_left[7:0], b};
            if (cnt == 0) cnt = 1;
            else if (body_left == 0) next_ext();
            else if (hold == EXT_MARK_SNI) enter(P_SNIHDR);
            else if (hold == EXT_MARK_CURVE) enter(P_CURVELEN);
            else if (hold == EXT_MARK_PF) enter(P_PFLEN);
            else enter(P_EXTSKIP);
         end
         P_EXTSKIP, P_SNIHDR, P_SNINAME, P_CURVELEN, P_CURVES, P_PFLEN, P_PF: begin
            inner_byte(b);
            if (phase != P_SINK) begin
               body_left--;
               if (body_left == 0) begin
                  if (phase != P_EXTSKIP) abort_parse(); else next_ext();
               end
            end
         end
         default: ;
      endcase
      if (eop) begin
         push_field((!parse_err && hello_done && rec_left == 0) ? K_ACCEPT : K_REJECT,
                    16'd0, 1);
         clear_parser();
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_parser();
         fields_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_port.valid && rsp_port.ready) begin
            if (fields_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected word kind=%0d value=%h done=%b",
                           rsp_port.field_kind, rsp_port.field_value,
                           rsp_port.packet_done);
            end else begin
               want = fields_due.pop_front();
               if (rsp_port.field_kind !== want.field_kind ||
                   rsp_port.field_value !== want.field_value ||
                   rsp_port.packet_done !== want.packet_done) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected kind=%0d value=%h done=%b, got %0d %h %b",
                              want.field_kind, want.field_value, want.packet_done,
                              rsp_port.field_kind, rsp_port.field_value,
                              rsp_port.packet_done);
               end
            end
         end
         if (req_port.valid && req_port.ready)
            parse_byte(req_port.data_byte, req_port.end_of_packet);
      end
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import thfe_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_count;

   thfe_req_if req_port();
   thfe_rsp_if rsp_port();

   tls_hello_field_extractor dut (
      .clock(clock), .reset(reset), .req_port(req_port), .rsp_port(rsp_port));

   thfe_checker checker_i (
      .clock(clock), .reset(reset), .req_port(req_port), .rsp_port(rsp_port),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   logic [7:0] pkt[$];

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver stalls
   initial begin
      rsp_port.ready = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 60) == 0) begin
            rsp_port.ready <= 0;
            repeat ($urandom_range(5, 25)) @(posedge clock);
            rsp_port.ready <= 1;
         end else begin
            rsp_port.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic put16(input logic [15:0] v);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
   endtask

   function automatic logic [15:0] pick_version();
      case ($urandom_range(0, 6))
         0: return VER_SSL2;
         1: return VER_SSL3;
         2: return VER_TLS10;
         3: return VER_TLS11;
         4: return VER_TLS12;
         default: return 16'($urandom);
      endcase
   endfunction

   // build a hello; mode selects special cases, 0 = random with no forced fault
   task automatic build_hello(input int mode, input logic server);
      logic [7:0] body[$];
      logic [7:0] ext[$];
      logic [7:0] eb[$];
      int n, k, sni_len, etype;
      logic [15:0] v;
      pkt.delete();
      // handshake body after the length
      body.delete();
      v = (mode == 2) ? 16'h0304 : pick_version();
      if (mode == 0 && $urandom_range(0, 3) != 0) v = VER_TLS12;
      body.push_back(v[15:8]); body.push_back(v[7:0]);
      repeat (32) body.push_back(8'($urandom));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : 0;
      body.push_back(8'(n));
      repeat (n) body.push_back(8'($urandom));
      if (server) begin
         body.push_back(8'($urandom)); body.push_back(8'($urandom)); body.push_back(8'd0);
      end else begin
         n = (mode == 3) ? $urandom_range(0, 1) : $urandom_range(1, 8) * 2 + $urandom_range(0, 1);
         body.push_back(8'(n >> 8)); body.push_back(8'(n));
         for (k = 0; k < n; k++)
            body.push_back((k % 2 == 0 || $urandom_range(0, 3) != 0) ? 8'($urandom) :
                           body[body.size() - 1]);
         if (n >= 2 && $urandom_range(0, 2) == 0) begin
            body[body.size() - 1] = 8'h5a; body[body.size() - 2] = 8'h5a;
         end
         n = $urandom_range(1, 2);
         body.push_back(8'(n));
         repeat (n) body.push_back(8'($urandom));
      end
      // extensions
      ext.delete();
      repeat ($urandom_range(mode == 4 ? 0 : 1, 4)) begin
         eb.delete();
         etype = $urandom_range(0, 5);
         case (etype)
            0: begin
               sni_len = (mode == 5) ? 256 + $urandom_range(0, 20) :
                         ($urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 12));
               eb.push_back(8'd0); eb.push_back(8'(sni_len + 3)); eb.push_back(8'd0);
               eb.push_back(8'(sni_len >> 8)); eb.push_back(8'(sni_len));
               repeat (sni_len) eb.push_back(8'($urandom));
               v = EXT_SNI;
            end
            1: begin
               n = $urandom_range(0, 5) * 2 + ($urandom_range(0, 3) == 0);
               eb.push_back(8'd0); eb.push_back(8'(n));
               repeat (n) eb.push_back(8'($urandom));
               v = EXT_CURVES;
            end
            2: begin
               n = $urandom_range(0, 4);
               eb.push_back(8'(n));
               repeat (n) eb.push_back(8'($urandom));
               v = EXT_POINT_FMT;
            end
            3: begin
               v = 16'h1a1a | (16'($urandom_range(0, 15)) << 12)
                   | (16'($urandom_range(0, 15)) << 4);
               v[7:4] = v[15:12];
               repeat ($urandom_range(0, 3)) eb.push_back(8'($urandom));
            end
            default: begin
               v = 16'($urandom);
               repeat ($urandom_range(0, 4)) eb.push_back(8'($urandom));
            end
         endcase
         if (mode == 6 && $urandom_range(0, 1)) begin
            if (eb.size() > 0) void'(eb.pop_back());
         end
         put_ext(ext, v, eb);
      end
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) ext.push_back(8'($urandom));
      body.push_back(8'(ext.size() >> 8)); body.push_back(8'(ext.size()));
      foreach (ext[i]) body.push_back(ext[i]);
      if (mode == 4 && !server) begin
         void'(body.pop_back()); void'(body.pop_back());
         body.push_back(8'd0); body.push_back(8'd0);
      end
      // record
      pkt.push_back((mode == 1) ? 8'h17 : REC_TYPE_HANDSHAKE);
      v = (mode == 2) ? 16'h0001 : pick_version();
      if (mode == 0 && $urandom_range(0, 3) != 0) v = VER_TLS10;
      put16(v);
      n = body.size() + 4;
      if (mode == 7) n = n + $urandom_range(1, 5);
      put16(16'(n));
      pkt.push_back(mode == 8 ? 8'd7 : (server ? MSG_SERVER_HELLO : MSG_CLIENT_HELLO));
      pkt.push_back(mode == 9 ? 8'h02 : 8'h00);
      put16(16'(body.size()));
      foreach (body[i]) pkt.push_back(body[i]);
      if (mode == 10) repeat ($urandom_range(1, body.size())) void'(pkt.pop_back());
      if (mode == 11) repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
   endtask

   task automatic put_ext(ref logic [7:0] ext[$], input logic [15:0] t,
                          input logic [7:0] eb[$]);
      ext.push_back(t[15:8]); ext.push_back(t[7:0]);
      ext.push_back(8'(eb.size() >> 8)); ext.push_back(8'(eb.size()));
      foreach (eb[i]) ext.push_back(eb[i]);
   endtask

   // valid stays high between packets; the next word or a gap replaces it
   task automatic send_packet(ref int sent);
      for (int i = 0; i < pkt.size(); i++) begin
         repeat (gap_len()) begin
            req_port.valid <= 0;
            @(posedge clock);
         end
         req_port.valid <= 1;
         req_port.data_byte <= pkt[i];
         req_port.end_of_packet <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_port.ready) @(posedge clock);
         sent++;
      end
   endtask

   initial begin
      int sent;
      int mode;
      int idx;
      sent = 0;
      idx = 0;
      req_port.valid = 0;
      req_port.data_byte = 0;
      req_port.end_of_packet = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed: single bytes incl. extremes
      pkt.delete(); pkt.push_back(8'h00); send_packet(sent);
      pkt.delete(); pkt.push_back(8'hff); send_packet(sent);
      pkt.delete(); pkt.push_back(8'h16); send_packet(sent);
      // mode 0 hellos alternate with special cases and raw noise
      while (sent < 450) begin
         if (idx % 6 == 5) begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
         end else begin
            mode = (idx % 2 == 0) ? 0 : $urandom_range(1, 11);
            build_hello(mode, $urandom_range(0, 3) == 0);
         end
         send_packet(sent);
         idx++;
      end
      req_port.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
